### rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and stream field layout for the linear probe hash table.
package lpht_pkg;

    localparam int TAG_W = 2;

    localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_DEAD  = 2'd2;

    localparam int REQ_W      = 2;
    localparam int KEY_IN_W   = 32;
    localparam int HOME_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 6;
    localparam int LIVE_OUT_W = 7;

    localparam int REQ_LSB  = 0;
    localparam int KEY_LSB  = REQ_LSB + REQ_W;
    localparam int HOME_LSB = KEY_LSB + KEY_IN_W;
    localparam int S_DATA_W = 40;

    localparam int STATUS_LSB = 0;
    localparam int SLOT_LSB   = STATUS_LSB + STATUS_W;
    localparam int LIVE_LSB   = SLOT_LSB + SLOT_OUT_W;
    localparam int M_DATA_W   = 16;

    localparam logic [REQ_W-1:0] OP_FIND   = 2'd0;
    localparam logic [REQ_W-1:0] OP_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic clear;
        logic load;
        logic probe;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic stop;
        logic out_busy;
    } dp_stat_t;

endpackage

### rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Top level of the open-addressing hash table with linear probing and tombstones.
//
// Each request (find, insert, delete) carries its key and home slot and yields one
// result. After reset the table is cleared one slot per cycle before the first request
// is taken. A request is then loaded and its slots probed in turn, since the slot RAM
// delivers one entry per cycle over its single read port; a probe stops at a match, an
// empty slot or a full circle, and its result is registered once the output register
// is free. An insert that finds no match and does not circle the table reuses the first
// tombstone or empty slot seen on the probe path, so no second pass is needed. The
// result waits in an output register; the next request is taken while it waits.
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = 64,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // req_type[1:0], key[33:2], home_slot[39:34]
    input  logic [lpht_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], slot[7:2], live_count[14:8]
    output logic [lpht_pkg::M_DATA_W-1:0] m_tdata
);

    import lpht_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpht_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/lpht_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lpht_datapath.sv
`timescale 1ns / 1ps
// Datapath: request registers, slot RAM, probe address, free-slot tracking and result register.
module lpht_datapath #(
    parameter int TABLE_SIZE = 64,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lpht_pkg::dp_cmd_t               cmd,
    output lpht_pkg::dp_stat_t              stat,
    input  logic [lpht_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [lpht_pkg::M_DATA_W-1:0]   m_tdata
);

    import lpht_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int LIVE_W  = $clog2(TABLE_SIZE + 1);
    localparam int ENTRY_W = TAG_W + KEY_WIDTH;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

    function automatic logic [HOME_W:0] reduce_home(input logic [HOME_W-1:0] h);
        logic [HOME_W:0] r;
        r = {1'b0, h};
        for (int k = HOME_W; k >= 0; k--)
        begin
            if (32'(r) >= (TABLE_SIZE << k))
            begin
                r = r - (HOME_W + 1)'(TABLE_SIZE << k);
            end
        end
        return r;
    endfunction

    logic [REQ_W-1:0]    req_in;
    logic [KEY_IN_W-1:0] key_in;
    logic [HOME_W-1:0]   home_in;
    logic [63:0]         key_wide;
    logic [31:0]         home_wide;
    logic [SLOT_W-1:0]   home_sel;

    logic [REQ_W-1:0]     op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [SLOT_W-1:0]    home_reg;
    logic [SLOT_W-1:0]    rd_addr_reg;
    logic                 free_found_reg;
    logic [SLOT_W-1:0]    free_slot_reg;
    logic [SLOT_W-1:0]    clr_addr_reg;
    logic [LIVE_W-1:0]    live_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [LIVE_OUT_W-1:0] out_live_reg;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [TAG_W-1:0]     rd_tag;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [SLOT_W-1:0]    next_addr;
    logic                 is_live;
    logic                 is_empty;
    logic                 hit;
    logic                 wrap;
    logic                 circled;
    logic [SLOT_W-1:0]    free_cand;

    logic [STATUS_W-1:0]  fin_status;
    logic [SLOT_W-1:0]    fin_slot;
    logic [LIVE_W-1:0]    fin_live;
    logic                 fin_we;
    logic [TAG_W-1:0]     fin_tag;
    logic [SLOT_W-1:0]    fin_waddr;
    logic [31:0]          fin_slot_wide;
    logic [31:0]          fin_live_wide;

    assign req_in    = s_tdata[REQ_LSB +: REQ_W];
    assign key_in    = s_tdata[KEY_LSB +: KEY_IN_W];
    assign home_in   = s_tdata[HOME_LSB +: HOME_W];
    assign key_wide  = {32'b0, key_in};
    assign home_wide = 32'(reduce_home(home_in));
    assign home_sel  = home_wide[SLOT_W-1:0];

    assign rd_tag    = ram_rdata[ENTRY_W-1 -: TAG_W];
    assign rd_key    = ram_rdata[KEY_WIDTH-1:0];
    assign next_addr = (rd_addr_reg == LAST_SLOT) ? '0 : rd_addr_reg + 1'b1;
    assign is_live   = (rd_tag == TAG_LIVE);
    assign is_empty  = !is_live && (rd_tag != TAG_DEAD);
    assign hit       = is_live && (rd_key == key_reg);
    assign wrap      = (next_addr == home_reg);
    assign circled   = !hit && !is_empty && wrap;
    assign free_cand = free_found_reg ? free_slot_reg : rd_addr_reg;

    always_comb
    begin
        fin_status = ST_NOT_FOUND;
        fin_slot   = (hit || is_empty) ? rd_addr_reg : home_reg;
        fin_live   = live_reg;
        fin_we     = 1'b0;
        fin_tag    = TAG_LIVE;
        fin_waddr  = rd_addr_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (hit)
                begin
                    fin_status = ST_PRESENT;
                end
                else if (circled)
                begin
                    fin_status = ST_FULL;
                end
                else
                begin
                    fin_status = ST_DONE;
                    fin_slot   = free_cand;
                    fin_waddr  = free_cand;
                    fin_we     = 1'b1;
                    fin_live   = live_reg + LIVE_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (hit)
                begin
                    fin_status = ST_DONE;
                    fin_we     = 1'b1;
                    fin_tag    = TAG_DEAD;
                    fin_live   = live_reg - LIVE_W'(1);
                end
            end
            default:
            begin
                fin_status = hit ? ST_DONE : ST_NOT_FOUND;
            end
        endcase
    end

    assign fin_slot_wide = 32'(fin_slot);
    assign fin_live_wide = 32'(fin_live);

    assign ram_we    = cmd.clear || (cmd.finish && fin_we);
    assign ram_waddr = cmd.clear ? clr_addr_reg : fin_waddr;
    assign ram_wdata = cmd.clear ? {TAG_EMPTY, {KEY_WIDTH{1'b0}}} : {fin_tag, key_reg};
    assign ram_re    = cmd.load || cmd.probe;
    assign ram_raddr = cmd.load ? home_sel : next_addr;

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req_in;
            key_reg  <= key_wide[KEY_WIDTH-1:0];
            home_reg <= home_sel;
        end
        if (ram_re)
        begin
            rd_addr_reg <= ram_raddr;
        end
        if (cmd.probe && !free_found_reg && !is_live)
        begin
            free_slot_reg <= rd_addr_reg;
        end
        if (cmd.finish)
        begin
            out_status_reg <= fin_status;
            out_slot_reg   <= fin_slot_wide[SLOT_OUT_W-1:0];
            out_live_reg   <= fin_live_wide[LIVE_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            live_reg       <= '0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                free_found_reg <= 1'b0;
            end
            else if (cmd.probe && !is_live)
            begin
                free_found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                live_reg      <= fin_live;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = (clr_addr_reg == LAST_SLOT);
    assign stat.stop       = hit || is_empty || wrap;
    assign stat.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_live_reg, out_slot_reg, out_status_reg};

endmodule

### rtl/lpht_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the clearing sweep, request load, probing and completion.
module lpht_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lpht_pkg::dp_stat_t  stat,
    output lpht_pkg::dp_cmd_t   cmd
);

    import lpht_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!stat.stop)
                begin
                    cmd.probe = 1'b1;
                end
                else if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### verif/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Stream testbench for the linear probe hash table: queued requests, in-order result checks.
module tb_linear_probe_hash_table;

    import lpht_pkg::*;

    localparam int TABLE_SIZE = 64;
    localparam int KEY_WIDTH  = 32;
    localparam int POOL_N     = 100;
    localparam int HOLD_CYCLES = 300;
    localparam logic [REQ_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]    op;
        logic [KEY_IN_W-1:0] key;
        logic [HOME_W-1:0]   home;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [LIVE_OUT_W-1:0] live;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    linear_probe_hash_table #(
        .TABLE_SIZE(TABLE_SIZE),
        .KEY_WIDTH(KEY_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    request_t request_queue[$];
    outcome_t expected_results[$];
    request_t offered_req;

    logic [TAG_W-1:0]    slot_tag [TABLE_SIZE];
    logic [KEY_IN_W-1:0] slot_key [TABLE_SIZE];
    int unsigned         live_entries = 0;
    int unsigned         tombstones = 0;

    logic [KEY_IN_W-1:0] key_pool [POOL_N];
    logic [HOME_W-1:0]   home_pool [POOL_N];

    int unsigned requests_accepted = 0;
    int unsigned fail_count = 0;
    int unsigned send_gap = 0;
    int unsigned sink_wait = 0;
    logic        sink_hold = 1'b0;
    logic        calm = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned idle_cycles();
        int unsigned r;
        if ($urandom_range(0, 199) == 0)
            calm = ~calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic outcome_t apply_request(request_t rq);
        outcome_t    res;
        int unsigned j;
        int unsigned stop_at;
        logic        found;
        logic        stopped;
        logic        circled;
        j = rq.home;
        stop_at = rq.home;
        found = 1'b0;
        stopped = 1'b0;
        circled = 1'b0;
        while (!stopped)
        begin
            if (slot_tag[j] == TAG_LIVE && slot_key[j] == rq.key)
            begin
                found = 1'b1;
                stopped = 1'b1;
                stop_at = j;
            end
            else if (slot_tag[j] == TAG_EMPTY)
            begin
                stopped = 1'b1;
                stop_at = j;
            end
            else
            begin
                j = (j + 1) % TABLE_SIZE;
                if (j == rq.home)
                begin
                    stopped = 1'b1;
                    circled = 1'b1;
                    stop_at = rq.home;
                end
            end
        end
        res.slot = SLOT_OUT_W'(stop_at);
        if (rq.op == OP_INSERT)
        begin
            if (found)
                res.status = ST_PRESENT;
            else if (circled)
                res.status = ST_FULL;
            else
            begin
                j = rq.home;
                while (slot_tag[j] == TAG_LIVE)
                    j = (j + 1) % TABLE_SIZE;
                if (slot_tag[j] == TAG_DEAD && tombstones > 0)
                    tombstones--;
                slot_tag[j] = TAG_LIVE;
                slot_key[j] = rq.key;
                live_entries++;
                res.status = ST_DONE;
                res.slot = SLOT_OUT_W'(j);
            end
        end
        else if (rq.op == OP_DELETE)
        begin
            if (found)
            begin
                slot_tag[stop_at] = TAG_DEAD;
                if (live_entries > 0)
                    live_entries--;
                tombstones++;
                res.status = ST_DONE;
            end
            else
                res.status = ST_NOT_FOUND;
        end
        else
            res.status = found ? ST_DONE : ST_NOT_FOUND;
        res.live = LIVE_OUT_W'(live_entries);
        return res;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_request(request_t rq);
        logic [S_DATA_W-1:0] v;
        v = '0;
        v[REQ_LSB +: REQ_W] = rq.op;
        v[KEY_LSB +: KEY_IN_W] = rq.key;
        v[HOME_LSB +: HOME_W] = rq.home;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_request(offered_req));
                requests_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    offered_req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= pack_request(offered_req);
                    send_gap = idle_cycles();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[STATUS_LSB +: STATUS_W];
                got.slot = m_tdata[SLOT_LSB +: SLOT_OUT_W];
                got.live = m_tdata[LIVE_LSB +: LIVE_OUT_W];
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transfer: status %0d slot %0d live %0d",
                                 got.status, got.slot, got.live);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status || got.slot != want.slot ||
                        got.live != want.live)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: status %0d/%0d slot %0d/%0d live %0d/%0d (exp/act)",
                                     want.status, got.status, want.slot, got.slot,
                                     want.live, got.live);
                    end
                end
            end
            if (sink_hold)
                m_tready <= 1'b0;
            else if (sink_wait > 0)
            begin
                sink_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                sink_wait = idle_cycles();
            end
        end
    end

    initial
    begin
        wait (requests_accepted >= 200);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    task automatic queue_request(logic [REQ_W-1:0] op, logic [KEY_IN_W-1:0] key,
                                 logic [HOME_W-1:0] home);
        request_t rq;
        rq.op = op;
        rq.key = key;
        rq.home = home;
        request_queue.push_back(rq);
    endtask

    task automatic wait_idle();
        while (request_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    function automatic request_t pick_request(int unsigned pool_n, int unsigned ins_w,
                                              int unsigned del_w);
        request_t    rq;
        int unsigned r;
        int unsigned idx;
        idx = $urandom_range(0, pool_n - 1);
        rq.key = key_pool[idx];
        rq.home = home_pool[idx];
        r = $urandom_range(0, 99);
        if (r < ins_w)
            rq.op = OP_INSERT;
        else if (r < ins_w + del_w)
            rq.op = OP_DELETE;
        else if (r < 95)
            rq.op = OP_FIND;
        else
            rq.op = OP_SPARE;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            rq.key = $urandom;
            rq.home = HOME_W'($urandom_range(0, TABLE_SIZE - 1));
            rq.op = REQ_W'($urandom_range(0, 3));
        end
        else if (r < 10)
            rq.home = HOME_W'($urandom_range(0, TABLE_SIZE - 1));
        return rq;
    endfunction

    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            slot_tag[i] = TAG_EMPTY;
            slot_key[i] = '0;
        end
        for (int i = 0; i < POOL_N; i++)
        begin
            key_pool[i] = $urandom;
            if (i % 4 == 0)
                home_pool[i] = HOME_W'($urandom_range(TABLE_SIZE - 4, TABLE_SIZE - 1));
            else
                home_pool[i] = HOME_W'($urandom_range(0, TABLE_SIZE - 1));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_request(OP_FIND,   32'h1234_5678, 6'd5);
        queue_request(OP_INSERT, 32'h0000_0000, 6'd0);
        queue_request(OP_FIND,   32'h0000_0000, 6'd0);
        queue_request(OP_INSERT, 32'h0000_0000, 6'd0);
        queue_request(OP_INSERT, 32'hFFFF_FFFF, 6'd63);
        queue_request(OP_INSERT, 32'hA5A5_A5A5, 6'd63);
        queue_request(OP_FIND,   32'hA5A5_A5A5, 6'd63);
        queue_request(OP_DELETE, 32'h0000_0000, 6'd0);
        queue_request(OP_FIND,   32'hA5A5_A5A5, 6'd63);
        queue_request(OP_DELETE, 32'h0000_0000, 6'd0);
        queue_request(OP_INSERT, 32'h5A5A_5A5A, 6'd0);
        queue_request(OP_SPARE,  32'h5A5A_5A5A, 6'd0);
        queue_request(OP_SPARE,  32'h0F0F_0F0F, 6'd42);
        queue_request(OP_FIND,   32'hFFFF_FFFF, 6'd62);
        queue_request(OP_DELETE, 32'hFFFF_FFFF, 6'd63);
        queue_request(OP_INSERT, 32'h8000_0001, 6'd63);
        queue_request(OP_FIND,   32'h8000_0001, 6'd63);
        queue_request(OP_INSERT, 32'h8000_0001, 6'd21);
        queue_request(OP_FIND,   32'h8000_0001, 6'd21);
        queue_request(OP_DELETE, 32'h7FFF_FFFE, 6'd1);
        wait_idle();

        for (int i = 0; i < 600; i++)
            request_queue.push_back(pick_request(40, 40, 25));
        wait_idle();

        for (int i = 0; i < 530; i++)
            request_queue.push_back(pick_request(POOL_N, 60, 20));
        wait_idle();

        repeat (2 * TABLE_SIZE + 16) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_datapath.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table.sv
verif/tb_linear_probe_hash_table.sv
